// ===== sv/largest_scc_edge_filter_defines.svh =====
// Assertion macros shared by the checker of largest_scc_edge_filter.
// Expects clk_i and rst_ni in the scope where the macros are used.
`ifndef LARGEST_SCC_EDGE_FILTER_DEFINES_SVH
`define LARGEST_SCC_EDGE_FILTER_DEFINES_SVH

// same-cycle implication
`define LSEF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LSEF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lsef_pkg.sv =====
// Package for largest_scc_edge_filter: sizes, codes, state and memory word types.
// No dependencies.
package lsef_pkg;

  localparam int MAX_NODES = 1024;
  localparam int MAX_EDGES = 4096;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = NODE_W + 1;
  localparam int EIDX_W    = $clog2(MAX_EDGES);
  localparam int EPTR_W    = EIDX_W + 1;
  localparam logic [EPTR_W-1:0] NIL_EDGE = EPTR_W'(MAX_EDGES);

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_FETCH = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_DROP  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    ST_INIT_CLR, ST_IDLE,
    ST_ADD_RD, ST_ADD_WR, ST_ADD_LINK,
    ST_RUN_CLR, ST_ROOT, ST_ROOT_CHK,
    ST_TOP, ST_TOP_RD, ST_U_LD, ST_CUR, ST_EDGE, ST_EDGE2, ST_V_CHK,
    ST_FIN_RD, ST_FIN_HEAD, ST_FIN_E, ST_FIN_E2, ST_FIN_E3, ST_FIN_E4, ST_FIN_CHK,
    ST_POP_RD, ST_POP_W, ST_POP_W2, ST_POP_END,
    ST_FT_N, ST_FT_N2, ST_FT_E, ST_FT_E2, ST_FT_E3
  } state_e;

  typedef struct packed {
    logic [CNT_W-1:0]  visit;
    logic [CNT_W-1:0]  low;
    logic              on_stk;
    logic [NODE_W-1:0] label;
    logic [EPTR_W-1:0] cursor;
  } node_t;

  typedef struct packed {
    logic [EPTR_W-1:0] head;
    logic [EPTR_W-1:0] tail;
  } list_t;

endpackage

// ===== sv/lsef_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module lsef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/lsef_cmp.sv =====
// Shared magnitude compare unit of the search and fetch sequencer.
// Depends on lsef_pkg.
module lsef_cmp (
  input  logic [lsef_pkg::CNT_W-1:0] a_i,
  input  logic [lsef_pkg::CNT_W-1:0] b_i,
  output logic                       lt_o,
  output logic                       eq_o
);

  assign lt_o = (a_i < b_i);
  assign eq_o = (a_i == b_i);

endmodule

// ===== sv/largest_scc_edge_filter.sv =====
// Top level: edge store, iterative Tarjan search sequencer and component edge fetch.
// Depends on lsef_pkg, lsef_ram, lsef_cmp.
//
//  channel  | handshake          | fields
//  ---------+--------------------+-----------------------------------------------
//  input    | start, busy        | mode_i, src_node_i, dst_node_i
//  result   | done_o (1 cycle)   | status_o, node_count_o, component_size_o,
//           |                    | edge_valid_o, edge_src_o, edge_dst_o
//
// Add reads the source list entry, writes it with the new edge and links the old tail;
// clear is bounded by the list memory sweep. Run sweeps the node memory, then visits
// nodes and edges; fetch scans nodes and the edges of each node.
// Every step goes through single-port memories, one access per memory per cycle.
// After reset a sweep of the list memory sets all list heads and tails to null; busy is high meanwhile.
// Results cannot be stalled: each appears for one cycle on done_o.
module largest_scc_edge_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [9:0]  src_node_i,
  input  logic [9:0]  dst_node_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [10:0] node_count_o,
  output logic [10:0] component_size_o,
  output logic        edge_valid_o,
  output logic [9:0]  edge_src_o,
  output logic [9:0]  edge_dst_o
);

  localparam int NW = lsef_pkg::NODE_W;
  localparam int CW = lsef_pkg::CNT_W;
  localparam int XW = lsef_pkg::EIDX_W;
  localparam int PW = lsef_pkg::EPTR_W;

  lsef_pkg::state_e st_q, st_d;
  logic [1:0]    mode_q, mode_d;
  logic [NW-1:0] src_q, src_d, dst_q, dst_d;
  logic [CW-1:0] clr_q, clr_d;
  logic [PW-1:0] etot_q, etot_d;
  logic [CW-1:0] ntot_q, ntot_d;
  logic [CW-1:0] stamp_q, stamp_d;
  logic [NW-1:0] blabel_q, blabel_d;
  logic [CW-1:0] bsize_q, bsize_d;
  logic [CW-1:0] cdep_q, cdep_d, sdep_q, sdep_d;
  logic [CW-1:0] root_q, root_d;
  logic [NW-1:0] u_q, u_d, v_q, v_d;
  lsef_pkg::node_t uw_q, uw_d;
  logic [PW-1:0] e_q, e_d, head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] cand_q, cand_d, cnt_q, cnt_d;
  logic [CW-1:0] fnode_q, fnode_d;
  logic [XW-1:0] flast_q, flast_d;
  logic          fstart_q, fstart_d, fin_q, fin_d, pend_q, pend_d;
  logic          done_q, done_d, ev_q, ev_d;
  logic [1:0]    stat_q, stat_d;
  logic [NW-1:0] es_q, es_d, ed_q, ed_d;

  // memory ports
  logic            list_we;
  logic [NW-1:0]   list_addr;
  lsef_pkg::list_t list_wdata, list_rdata;
  logic            node_we;
  logic [NW-1:0]   node_addr;
  lsef_pkg::node_t node_wdata, node_rdata;
  logic            tgt_we, nxt_we;
  logic [XW-1:0]   tgt_addr, nxt_addr;
  logic [NW-1:0]   tgt_wdata, tgt_rdata;
  logic [PW-1:0]   nxt_wdata, nxt_rdata;
  logic            cstk_we, sstk_we;
  logic [NW-1:0]   cstk_addr, sstk_addr, cstk_wdata, sstk_wdata, cstk_rdata, sstk_rdata;

  logic [CW-1:0] cmp_a, cmp_b;
  logic          cmp_lt, cmp_eq;

  // entering a node and finishing an item are shared by several states
  logic          enter_en;
  logic [NW-1:0] enter_n;
  logic [PW-1:0] enter_h;
  logic          fin_en, fin_valid;
  logic [1:0]    fin_stat;
  logic [NW-1:0] top_id;

  assign top_id = (src_q > dst_q) ? src_q : dst_q;

  lsef_ram #(.WIDTH($bits(lsef_pkg::list_t)), .DEPTH(lsef_pkg::MAX_NODES)) u_list_ram (
    .clk_i(clk_i), .we_i(list_we), .addr_i(list_addr), .wdata_i(list_wdata),
    .rdata_o(list_rdata));
  lsef_ram #(.WIDTH($bits(lsef_pkg::node_t)), .DEPTH(lsef_pkg::MAX_NODES)) u_node_ram (
    .clk_i(clk_i), .we_i(node_we), .addr_i(node_addr), .wdata_i(node_wdata),
    .rdata_o(node_rdata));
  lsef_ram #(.WIDTH(NW), .DEPTH(lsef_pkg::MAX_EDGES)) u_tgt_ram (
    .clk_i(clk_i), .we_i(tgt_we), .addr_i(tgt_addr), .wdata_i(tgt_wdata),
    .rdata_o(tgt_rdata));
  lsef_ram #(.WIDTH(PW), .DEPTH(lsef_pkg::MAX_EDGES)) u_nxt_ram (
    .clk_i(clk_i), .we_i(nxt_we), .addr_i(nxt_addr), .wdata_i(nxt_wdata),
    .rdata_o(nxt_rdata));
  lsef_ram #(.WIDTH(NW), .DEPTH(lsef_pkg::MAX_NODES)) u_cstk_ram (
    .clk_i(clk_i), .we_i(cstk_we), .addr_i(cstk_addr), .wdata_i(cstk_wdata),
    .rdata_o(cstk_rdata));
  lsef_ram #(.WIDTH(NW), .DEPTH(lsef_pkg::MAX_NODES)) u_sstk_ram (
    .clk_i(clk_i), .we_i(sstk_we), .addr_i(sstk_addr), .wdata_i(sstk_wdata),
    .rdata_o(sstk_rdata));

  lsef_cmp u_cmp (.a_i(cmp_a), .b_i(cmp_b), .lt_o(cmp_lt), .eq_o(cmp_eq));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= lsef_pkg::ST_INIT_CLR;
      clr_q    <= '0;
      etot_q   <= '0;
      ntot_q   <= '0;
      stamp_q  <= '0;
      blabel_q <= '0;
      bsize_q  <= '0;
      cdep_q   <= '0;
      sdep_q   <= '0;
      root_q   <= '0;
      fnode_q  <= '0;
      flast_q  <= '0;
      fstart_q <= 1'b0;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      st_q     <= st_d;
      clr_q    <= clr_d;
      etot_q   <= etot_d;
      ntot_q   <= ntot_d;
      stamp_q  <= stamp_d;
      blabel_q <= blabel_d;
      bsize_q  <= bsize_d;
      cdep_q   <= cdep_d;
      sdep_q   <= sdep_d;
      root_q   <= root_d;
      fnode_q  <= fnode_d;
      flast_q  <= flast_d;
      fstart_q <= fstart_d;
      pend_q   <= pend_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    src_q  <= src_d;
    dst_q  <= dst_d;
    u_q    <= u_d;
    v_q    <= v_d;
    uw_q   <= uw_d;
    e_q    <= e_d;
    head_q <= head_d;
    tail_q <= tail_d;
    cand_q <= cand_d;
    cnt_q  <= cnt_d;
    fin_q  <= fin_d;
    ev_q   <= ev_d;
    stat_q <= stat_d;
    es_q   <= es_d;
    ed_q   <= ed_d;
  end

  always_comb begin
    st_d = st_q;     mode_d = mode_q;   src_d = src_q;     dst_d = dst_q;
    clr_d = clr_q;   etot_d = etot_q;   ntot_d = ntot_q;   stamp_d = stamp_q;
    blabel_d = blabel_q; bsize_d = bsize_q; cdep_d = cdep_q; sdep_d = sdep_q;
    root_d = root_q; u_d = u_q; v_d = v_q; uw_d = uw_q; e_d = e_q;
    head_d = head_q; tail_d = tail_q; cand_d = cand_q; cnt_d = cnt_q;
    fnode_d = fnode_q; flast_d = flast_q; fstart_d = fstart_q; fin_d = fin_q;
    pend_d = pend_q; done_d = 1'b0; ev_d = ev_q; stat_d = stat_q;
    es_d = es_q; ed_d = ed_q;

    list_we = 1'b0; list_addr = '0; list_wdata = '0;
    node_we = 1'b0; node_addr = '0; node_wdata = '0;
    tgt_we = 1'b0; tgt_addr = '0; tgt_wdata = '0;
    nxt_we = 1'b0; nxt_addr = '0; nxt_wdata = '0;
    cstk_we = 1'b0; cstk_addr = '0; cstk_wdata = '0;
    sstk_we = 1'b0; sstk_addr = '0; sstk_wdata = '0;
    cmp_a = '0; cmp_b = '0;
    enter_en = 1'b0; enter_n = '0; enter_h = lsef_pkg::NIL_EDGE;
    fin_en = 1'b0; fin_valid = 1'b0; fin_stat = lsef_pkg::STAT_OK;

    case (st_q)
      lsef_pkg::ST_INIT_CLR: begin
        list_we    = 1'b1;
        list_addr  = clr_q[NW-1:0];
        list_wdata = '{head: lsef_pkg::NIL_EDGE, tail: lsef_pkg::NIL_EDGE};
        clr_d      = clr_q + 1'b1;
        if (clr_q == CW'(lsef_pkg::MAX_NODES - 1)) begin
          clr_d = '0;
          st_d  = lsef_pkg::ST_IDLE;
          if (pend_q) begin
            fin_en = 1'b1;
          end
        end
      end
      lsef_pkg::ST_IDLE: begin
        if (start) begin
          mode_d = mode_i;
          src_d  = src_node_i;
          dst_d  = dst_node_i;
          case (lsef_pkg::mode_e'(mode_i))
            lsef_pkg::MODE_ADD:   st_d = lsef_pkg::ST_ADD_RD;
            lsef_pkg::MODE_RUN: begin
              clr_d = '0;  stamp_d = '0; blabel_d = '0; bsize_d = '0;
              cdep_d = '0; sdep_d = '0;  root_d = '0;
              st_d = lsef_pkg::ST_RUN_CLR;
            end
            lsef_pkg::MODE_FETCH: st_d = lsef_pkg::ST_FT_N;
            default: begin
              etot_d = '0;  ntot_d = '0; stamp_d = '0; blabel_d = '0; bsize_d = '0;
              cdep_d = '0;  sdep_d = '0; root_d = '0;  fnode_d = '0;  flast_d = '0;
              fstart_d = 1'b0; clr_d = '0; pend_d = 1'b1;
              st_d = lsef_pkg::ST_INIT_CLR;
            end
          endcase
        end
      end
      // ---- edge add ----
      lsef_pkg::ST_ADD_RD: begin
        if (etot_q == PW'(lsef_pkg::MAX_EDGES)) begin
          fin_en   = 1'b1;
          fin_stat = lsef_pkg::STAT_DROP;
        end else begin
          list_addr = src_q;
          st_d      = lsef_pkg::ST_ADD_WR;
        end
      end
      lsef_pkg::ST_ADD_WR: begin
        tail_d     = list_rdata.tail;
        list_we    = 1'b1;
        list_addr  = src_q;
        list_wdata.head = (list_rdata.tail == lsef_pkg::NIL_EDGE) ? etot_q : list_rdata.head;
        list_wdata.tail = etot_q;
        tgt_we    = 1'b1;
        tgt_addr  = etot_q[XW-1:0];
        tgt_wdata = dst_q;
        nxt_we    = 1'b1;
        nxt_addr  = etot_q[XW-1:0];
        nxt_wdata = lsef_pkg::NIL_EDGE;
        etot_d    = etot_q + 1'b1;
        if ({1'b0, top_id} + CW'(1) > ntot_q) begin
          ntot_d = {1'b0, top_id} + CW'(1);
        end
        st_d = lsef_pkg::ST_ADD_LINK;
      end
      lsef_pkg::ST_ADD_LINK: begin
        // chain the previous tail to the new edge
        if (tail_q != lsef_pkg::NIL_EDGE) begin
          nxt_we    = 1'b1;
          nxt_addr  = tail_q[XW-1:0];
          nxt_wdata = etot_q - 1'b1;
        end
        fin_en = 1'b1;
      end
      // ---- search ----
      lsef_pkg::ST_RUN_CLR: begin
        node_we   = 1'b1;
        node_addr = clr_q[NW-1:0];
        clr_d     = clr_q + 1'b1;
        if (clr_q == CW'(lsef_pkg::MAX_NODES - 1)) begin
          clr_d = '0;
          st_d  = lsef_pkg::ST_ROOT;
        end
      end
      lsef_pkg::ST_ROOT: begin
        cmp_a = root_q;
        cmp_b = ntot_q;
        if (!cmp_lt) begin
          fnode_d  = '0;
          flast_d  = '0;
          fstart_d = 1'b0;
          fin_en   = 1'b1;
        end else begin
          list_addr = root_q[NW-1:0];
          node_addr = root_q[NW-1:0];
          st_d      = lsef_pkg::ST_ROOT_CHK;
        end
      end
      lsef_pkg::ST_ROOT_CHK: begin
        if (list_rdata.head == lsef_pkg::NIL_EDGE || node_rdata.visit != '0) begin
          root_d = root_q + 1'b1;
          st_d   = lsef_pkg::ST_ROOT;
        end else begin
          enter_en = 1'b1;
          enter_n  = root_q[NW-1:0];
          enter_h  = list_rdata.head;
          st_d     = lsef_pkg::ST_TOP;
        end
      end
      lsef_pkg::ST_TOP: begin
        if (sdep_q == '0) begin
          root_d = root_q + 1'b1;
          st_d   = lsef_pkg::ST_ROOT;
        end else begin
          sstk_addr = NW'(sdep_q - 1'b1);
          st_d      = lsef_pkg::ST_TOP_RD;
        end
      end
      lsef_pkg::ST_TOP_RD: begin
        u_d       = sstk_rdata;
        node_addr = sstk_rdata;
        st_d      = lsef_pkg::ST_U_LD;
      end
      lsef_pkg::ST_U_LD: begin
        uw_d = node_rdata;
        st_d = lsef_pkg::ST_CUR;
      end
      lsef_pkg::ST_CUR: begin
        if (uw_q.cursor == lsef_pkg::NIL_EDGE) begin
          st_d = lsef_pkg::ST_FIN_RD;
        end else begin
          tgt_addr = uw_q.cursor[XW-1:0];
          nxt_addr = uw_q.cursor[XW-1:0];
          st_d     = lsef_pkg::ST_EDGE;
        end
      end
      lsef_pkg::ST_EDGE: begin
        v_d               = tgt_rdata;
        uw_d.cursor       = nxt_rdata;
        node_we           = 1'b1;
        node_addr         = u_q;
        node_wdata        = uw_q;
        node_wdata.cursor = nxt_rdata;
        list_addr         = tgt_rdata;
        st_d              = lsef_pkg::ST_EDGE2;
      end
      lsef_pkg::ST_EDGE2: begin
        head_d    = list_rdata.head;
        node_addr = v_q;
        st_d      = lsef_pkg::ST_V_CHK;
      end
      lsef_pkg::ST_V_CHK: begin
        if (node_rdata.visit == '0) begin
          enter_en = 1'b1;
          enter_n  = v_q;
          enter_h  = head_q;
          st_d     = lsef_pkg::ST_TOP;
        end else begin
          st_d = lsef_pkg::ST_CUR;
        end
      end
      // ---- low link pass over all out-edges of u ----
      lsef_pkg::ST_FIN_RD: begin
        list_addr = u_q;
        st_d      = lsef_pkg::ST_FIN_HEAD;
      end
      lsef_pkg::ST_FIN_HEAD: begin
        e_d  = list_rdata.head;
        st_d = lsef_pkg::ST_FIN_E;
      end
      lsef_pkg::ST_FIN_E: begin
        if (e_q == lsef_pkg::NIL_EDGE) begin
          st_d = lsef_pkg::ST_FIN_CHK;
        end else begin
          tgt_addr = e_q[XW-1:0];
          nxt_addr = e_q[XW-1:0];
          st_d     = lsef_pkg::ST_FIN_E2;
        end
      end
      lsef_pkg::ST_FIN_E2: begin
        e_d       = nxt_rdata;
        node_addr = tgt_rdata;
        st_d      = lsef_pkg::ST_FIN_E3;
      end
      lsef_pkg::ST_FIN_E3: begin
        cmp_a = uw_q.visit;
        cmp_b = node_rdata.visit;
        if (cmp_lt) begin
          cand_d = node_rdata.low;        // tree descendant
          st_d   = lsef_pkg::ST_FIN_E4;
        end else if (node_rdata.on_stk) begin
          cand_d = node_rdata.visit;      // back or cross edge into the stack
          st_d   = lsef_pkg::ST_FIN_E4;
        end else begin
          st_d = lsef_pkg::ST_FIN_E;
        end
      end
      lsef_pkg::ST_FIN_E4: begin
        cmp_a = cand_q;
        cmp_b = uw_q.low;
        if (cmp_lt) begin
          uw_d.low = cand_q;
        end
        st_d = lsef_pkg::ST_FIN_E;
      end
      lsef_pkg::ST_FIN_CHK: begin
        node_we    = 1'b1;
        node_addr  = u_q;
        node_wdata = uw_q;
        cmp_a      = uw_q.visit;
        cmp_b      = uw_q.low;
        if (cmp_eq) begin
          cnt_d = '0;
          st_d  = lsef_pkg::ST_POP_RD;
        end else begin
          sdep_d = sdep_q - 1'b1;
          st_d   = lsef_pkg::ST_TOP;
        end
      end
      // ---- pop one component ----
      lsef_pkg::ST_POP_RD: begin
        if (cdep_q == '0) begin
          st_d = lsef_pkg::ST_POP_END;
        end else begin
          cstk_addr = NW'(cdep_q - 1'b1);
          cdep_d    = cdep_q - 1'b1;
          st_d      = lsef_pkg::ST_POP_W;
        end
      end
      lsef_pkg::ST_POP_W: begin
        v_d       = cstk_rdata;
        node_addr = cstk_rdata;
        st_d      = lsef_pkg::ST_POP_W2;
      end
      lsef_pkg::ST_POP_W2: begin
        node_we           = 1'b1;
        node_addr         = v_q;
        node_wdata        = node_rdata;
        node_wdata.on_stk = 1'b0;
        node_wdata.label  = u_q;
        cnt_d             = cnt_q + 1'b1;
        st_d = (v_q == u_q) ? lsef_pkg::ST_POP_END : lsef_pkg::ST_POP_RD;
      end
      lsef_pkg::ST_POP_END: begin
        cmp_a = bsize_q;
        cmp_b = cnt_q;
        if (cmp_lt) begin
          bsize_d  = cnt_q;
          blabel_d = u_q;
        end
        sdep_d = sdep_q - 1'b1;
        st_d   = lsef_pkg::ST_TOP;
      end
      // ---- fetch ----
      lsef_pkg::ST_FT_N: begin
        cmp_a = fnode_q;
        cmp_b = ntot_q;
        if (bsize_q == '0 || !cmp_lt) begin
          fin_en   = 1'b1;
          fin_stat = lsef_pkg::STAT_EMPTY;
        end else begin
          nxt_addr  = flast_q;
          list_addr = fnode_q[NW-1:0];
          node_addr = fnode_q[NW-1:0];
          st_d      = lsef_pkg::ST_FT_N2;
        end
      end
      lsef_pkg::ST_FT_N2: begin
        e_d   = fstart_q ? nxt_rdata : list_rdata.head;
        fin_d = (node_rdata.visit != '0) && (node_rdata.label == blabel_q);
        st_d  = lsef_pkg::ST_FT_E;
      end
      lsef_pkg::ST_FT_E: begin
        if (e_q == lsef_pkg::NIL_EDGE) begin
          fnode_d  = fnode_q + 1'b1;
          fstart_d = 1'b0;
          st_d     = lsef_pkg::ST_FT_N;
        end else begin
          fstart_d = 1'b1;
          flast_d  = e_q[XW-1:0];
          tgt_addr = e_q[XW-1:0];
          nxt_addr = e_q[XW-1:0];
          st_d     = lsef_pkg::ST_FT_E2;
        end
      end
      lsef_pkg::ST_FT_E2: begin
        v_d       = tgt_rdata;
        e_d       = nxt_rdata;
        node_addr = tgt_rdata;
        st_d      = lsef_pkg::ST_FT_E3;
      end
      lsef_pkg::ST_FT_E3: begin
        if (fin_q && node_rdata.visit != '0 && node_rdata.label == blabel_q) begin
          fin_en    = 1'b1;
          fin_valid = 1'b1;
        end else begin
          st_d = lsef_pkg::ST_FT_E;
        end
      end
      default: st_d = lsef_pkg::ST_IDLE;
    endcase

    if (enter_en) begin
      stamp_d    = stamp_q + 1'b1;
      node_we    = 1'b1;
      node_addr  = enter_n;
      node_wdata = '{visit: stamp_q + 1'b1, low: stamp_q + 1'b1, on_stk: 1'b1,
                     label: '0, cursor: enter_h};
      cstk_we    = 1'b1;
      cstk_addr  = cdep_q[NW-1:0];
      cstk_wdata = enter_n;
      cdep_d     = cdep_q + 1'b1;
      sstk_we    = 1'b1;
      sstk_addr  = sdep_q[NW-1:0];
      sstk_wdata = enter_n;
      sdep_d     = sdep_q + 1'b1;
    end

    if (fin_en) begin
      done_d = 1'b1;
      pend_d = 1'b0;
      stat_d = fin_stat;
      ev_d   = fin_valid;
      es_d   = fin_valid ? fnode_q[NW-1:0] : '0;
      ed_d   = fin_valid ? v_q : '0;
      st_d   = lsef_pkg::ST_IDLE;
    end
  end

  assign busy             = (st_q != lsef_pkg::ST_IDLE);
  assign done_o           = done_q;
  assign status_o         = stat_q;
  assign node_count_o     = ntot_q;
  assign component_size_o = bsize_q;
  assign edge_valid_o     = ev_q;
  assign edge_src_o       = es_q;
  assign edge_dst_o       = ed_q;

endmodule

// ===== sv/lsef_chk.sv =====
// Port-level checker for largest_scc_edge_filter, bound to the top level.
// Depends on lsef_pkg and largest_scc_edge_filter_defines.svh.
`include "largest_scc_edge_filter_defines.svh"

module lsef_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  mode_i,
  input logic [9:0]  src_node_i,
  input logic [9:0]  dst_node_i,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [10:0] node_count_o,
  input logic [10:0] component_size_o,
  input logic        edge_valid_o,
  input logic [9:0]  edge_src_o,
  input logic [9:0]  edge_dst_o
);

  `LSEF_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `LSEF_ASSERT_IMP(a_done_idle, done_o, !busy, "result shown while busy")
  `LSEF_ASSERT_NXT(a_done_once, done_o, !done_o, "result strobe longer than one cycle")
  `LSEF_ASSERT_IMP(a_edge_ok, done_o && edge_valid_o, status_o == lsef_pkg::STAT_OK,
                   "fetched edge with bad status")
  `LSEF_ASSERT_IMP(a_empty_noedge, done_o && status_o == lsef_pkg::STAT_EMPTY,
                   !edge_valid_o && edge_src_o == '0 && edge_dst_o == '0,
                   "empty fetch carries an edge")

endmodule

bind largest_scc_edge_filter lsef_chk u_lsef_chk (.*);

// ===== bench/tb.sv =====
// Self-checking bench for largest_scc_edge_filter: random graph builds, searches and fetches.
// Depends on lsef_pkg and the block's RTL; carries its own Tarjan predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0] mode;
    logic [9:0] src;
    logic [9:0] dst;
  } cmd_t;

  typedef struct {
    logic [1:0]  status;
    logic [10:0] node_count;
    logic [10:0] comp_size;
    logic        edge_valid;
    logic [9:0]  edge_src;
    logic [9:0]  edge_dst;
  } resp_t;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  mode_i = '0;
  logic [9:0]  src_node_i = '0;
  logic [9:0]  dst_node_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [10:0] node_count_o;
  logic [10:0] component_size_o;
  logic        edge_valid_o;
  logic [9:0]  edge_src_o;
  logic [9:0]  edge_dst_o;

  largest_scc_edge_filter uut (.*);

  always #10 clk_i = ~clk_i;

  // graph and search state of the predictor
  int g_dst[lsef_pkg::MAX_EDGES];
  int g_nxt[lsef_pkg::MAX_EDGES];
  int g_head[lsef_pkg::MAX_NODES];
  int g_tail[lsef_pkg::MAX_NODES];
  int n_visit[lsef_pkg::MAX_NODES];
  int n_low[lsef_pkg::MAX_NODES];
  bit n_onstk[lsef_pkg::MAX_NODES];
  int n_label[lsef_pkg::MAX_NODES];
  int n_cur[lsef_pkg::MAX_NODES];
  int scc_stk[$];
  int dfs_stk[$];
  int stamp, best_lbl, best_sz, n_edges, n_nodes;
  int f_node, f_last;
  bit f_started;

  cmd_t  pending_cmds[$];
  resp_t expected_resps[$];
  int    errors, n_accepted, n_results, n_fetch_hits, n_runs, best_seen;

  function automatic void graph_clear();
    for (int i = 0; i < lsef_pkg::MAX_NODES; i++) begin
      g_head[i] = lsef_pkg::MAX_EDGES; g_tail[i] = lsef_pkg::MAX_EDGES;
      n_visit[i] = 0; n_low[i] = 0; n_onstk[i] = 0; n_label[i] = 0;
    end
    scc_stk.delete(); dfs_stk.delete();
    stamp = 0; best_lbl = 0; best_sz = 0; n_edges = 0; n_nodes = 0;
    f_node = 0; f_last = 0; f_started = 0;
  endfunction

  function automatic void visit_node(int n);
    stamp++;
    n_visit[n] = stamp; n_low[n] = stamp; n_onstk[n] = 1;
    n_cur[n] = g_head[n];
    scc_stk.insert(scc_stk.size(), n); dfs_stk.insert(dfs_stk.size(), n);
  endfunction

  function automatic void close_node(int u);
    int e, v, w, cnt;
    e = g_head[u];
    while (e < lsef_pkg::MAX_EDGES) begin
      v = g_dst[e];
      if (n_visit[v] > n_visit[u]) begin
        if (n_low[v] < n_low[u]) n_low[u] = n_low[v];
      end else if (n_onstk[v]) begin
        if (n_visit[v] < n_low[u]) n_low[u] = n_visit[v];
      end
      e = g_nxt[e];
    end
    if (n_visit[u] == n_low[u]) begin
      cnt = 0;
      while (scc_stk.size() > 0) begin
        w = scc_stk.pop_back();
        n_onstk[w] = 0; n_label[w] = u; cnt++;
        if (w == u) break;
      end
      if (cnt > best_sz) begin
        best_sz = cnt; best_lbl = u;
      end
    end
  endfunction

  function automatic void tarjan_search();
    int u, e, v;
    bit down;
    for (int i = 0; i < lsef_pkg::MAX_NODES; i++) begin
      n_visit[i] = 0; n_low[i] = 0; n_onstk[i] = 0;
    end
    scc_stk.delete(); dfs_stk.delete();
    stamp = 0; best_lbl = 0; best_sz = 0;
    for (int r = 0; r < n_nodes; r++) begin
      if (g_head[r] == lsef_pkg::MAX_EDGES || n_visit[r] != 0) continue;
      visit_node(r);
      while (dfs_stk.size() > 0) begin
        u = dfs_stk[$];
        down = 0;
        while (n_cur[u] < lsef_pkg::MAX_EDGES) begin
          e = n_cur[u];
          v = g_dst[e];
          n_cur[u] = g_nxt[e];
          if (n_visit[v] == 0) begin
            visit_node(v); down = 1; break;
          end
        end
        if (!down) begin
          close_node(u);
          void'(dfs_stk.pop_back());
        end
      end
    end
    f_node = 0; f_last = 0; f_started = 0;
  endfunction

  function automatic bit in_largest(int n);
    return n_visit[n] != 0 && n_label[n] == best_lbl;
  endfunction

  function automatic bit next_scc_edge(output int s, output int d);
    int e;
    s = 0; d = 0;
    if (best_sz == 0) return 0;
    while (f_node < n_nodes) begin
      e = f_started ? g_nxt[f_last] : g_head[f_node];
      while (e < lsef_pkg::MAX_EDGES) begin
        f_started = 1; f_last = e;
        if (in_largest(f_node) && in_largest(g_dst[e])) begin
          s = f_node; d = g_dst[e];
          return 1;
        end
        e = g_nxt[e];
      end
      f_node++; f_started = 0;
    end
    return 0;
  endfunction

  function automatic resp_t apply_cmd(cmd_t c);
    resp_t r;
    int s, d, top;
    r = '{default: '0};
    case (lsef_pkg::mode_e'(c.mode))
      lsef_pkg::MODE_ADD: begin
        if (n_edges >= lsef_pkg::MAX_EDGES) r.status = lsef_pkg::STAT_DROP;
        else begin
          g_dst[n_edges] = c.dst; g_nxt[n_edges] = lsef_pkg::MAX_EDGES;
          if (g_tail[c.src] < lsef_pkg::MAX_EDGES) g_nxt[g_tail[c.src]] = n_edges;
          else g_head[c.src] = n_edges;
          g_tail[c.src] = n_edges;
          n_edges++;
          top = (c.src > c.dst ? c.src : c.dst) + 1;
          if (top > n_nodes) n_nodes = top;
        end
      end
      lsef_pkg::MODE_RUN: begin
        tarjan_search();
        n_runs++;
        if (best_sz > best_seen) best_seen = best_sz;
      end
      lsef_pkg::MODE_FETCH: begin
        if (next_scc_edge(s, d)) begin
          r.edge_valid = 1; r.edge_src = s; r.edge_dst = d; n_fetch_hits++;
        end else r.status = lsef_pkg::STAT_EMPTY;
      end
      default: graph_clear();
    endcase
    r.node_count = n_nodes;
    r.comp_size = best_sz;
    return r;
  endfunction

  // driver: one item per handshake, random gaps, hold-offs marked by mode 'x' sentinel
  int gap;
  bit drain_wait;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_resps.insert(expected_resps.size(),
                              apply_cmd('{mode_i, src_node_i, dst_node_i}));
        n_accepted++;
      end
      if (start && busy) begin
        // keep presenting the same item
      end else if (gap > 0) begin
        gap <= gap - 1;
        start <= 0;
      end else if (drain_wait) begin
        start <= 0;
        if (expected_resps.size() == 0 && !(start && !busy)) drain_wait <= 0;
      end else if (pending_cmds.size() > 0) begin
        cmd_t c;
        c = pending_cmds.pop_front();
        if (c.mode === 2'bxx) begin
          drain_wait <= 1;
          start <= 0;
        end else begin
          start <= 1;
          mode_i <= c.mode; src_node_i <= c.src; dst_node_i <= c.dst;
          gap <= ($urandom_range(0, 9) < 6) ? 0 :
                 ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        end
      end else start <= 0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      n_results++;
      if (expected_resps.size() == 0) begin
        $display("%0t: unexpected result status=%0d", $time, status_o);
        errors++;
      end else begin
        resp_t x;
        x = expected_resps.pop_front();
        if (status_o !== x.status || node_count_o !== x.node_count ||
            component_size_o !== x.comp_size || edge_valid_o !== x.edge_valid ||
            edge_src_o !== x.edge_src || edge_dst_o !== x.edge_dst) begin
          $display("%0t: mismatch expected st=%0d nc=%0d cs=%0d v=%0d %0d->%0d", $time,
                   x.status, x.node_count, x.comp_size, x.edge_valid, x.edge_src,
                   x.edge_dst);
          $display("%0t:          actual   st=%0d nc=%0d cs=%0d v=%0d %0d->%0d", $time,
                   status_o, node_count_o, component_size_o, edge_valid_o, edge_src_o,
                   edge_dst_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  int idle_cycles;
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 200000) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push(lsef_pkg::mode_e m, int s = 0, int d = 0);
    cmd_t c;
    c = '{m, s[9:0], d[9:0]};
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  task automatic push_pause();
    cmd_t c;
    c = '{2'bxx, 10'd0, 10'd0};
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  // random graph with clustered ids so cycles form; content random
  task automatic push_graph(int nn, int ne, int base);
    for (int i = 0; i < ne; i++) begin
      if ($urandom_range(0, 19) == 0)
        push(lsef_pkg::MODE_ADD, $urandom_range(0, 1023), $urandom_range(0, 1023));
      else
        push(lsef_pkg::MODE_ADD, base + $urandom_range(0, nn - 1),
             base + $urandom_range(0, nn - 1));
    end
  endtask

  int total, nn, ne;
  initial begin
    graph_clear();
    errors = 0; n_accepted = 0; n_results = 0; n_fetch_hits = 0; n_runs = 0;
    best_seen = 0; gap = 0; drain_wait = 0; idle_cycles = 0;
    // directed: empty graph, extremes, small cycle, self loop, adds after a run
    push(lsef_pkg::MODE_FETCH);
    push(lsef_pkg::MODE_RUN);
    push(lsef_pkg::MODE_FETCH);
    push(lsef_pkg::MODE_ADD, 1023, 0);
    push(lsef_pkg::MODE_ADD, 0, 1023);
    push(lsef_pkg::MODE_ADD, 5, 5);
    push(lsef_pkg::MODE_ADD, 2, 3);
    push(lsef_pkg::MODE_ADD, 3, 2);
    push(lsef_pkg::MODE_ADD, 682, 341);
    push(lsef_pkg::MODE_ADD, 341, 682);
    push(lsef_pkg::MODE_RUN);
    for (int i = 0; i < 4; i++) push(lsef_pkg::MODE_FETCH);
    push(lsef_pkg::MODE_ADD, 0, 1023);
    push(lsef_pkg::MODE_ADD, 7, 8);
    for (int i = 0; i < 3; i++) push(lsef_pkg::MODE_FETCH);
    push(lsef_pkg::MODE_CLEAR);
    push(lsef_pkg::MODE_FETCH);
    push_pause();
    total = 0;
    while (total < 1100) begin
      nn = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(2, 10);
      ne = $urandom_range(1, nn * 2);
      push_graph(nn, ne, $urandom_range(0, 1023 - nn));
      push(lsef_pkg::MODE_RUN);
      for (int i = $urandom_range(1, ne + 2); i > 0; i--) begin
        if ($urandom_range(0, 15) == 0) push(lsef_pkg::MODE_ADD, $urandom_range(0, 1023), 0);
        else push(lsef_pkg::MODE_FETCH);
        total++;
      end
      if ($urandom_range(0, 5) == 0) push_pause();
      if ($urandom_range(0, 2) != 0) push(lsef_pkg::MODE_CLEAR);
      total += ne + 2;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    while (pending_cmds.size() != 0 || start || drain_wait) @(posedge clk_i);
    while (expected_resps.size() != 0) @(posedge clk_i);
    repeat (3000) @(posedge clk_i);
    $display("%0d items, %0d results, %0d searches, %0d component edges, largest %0d",
             n_accepted, n_results, n_runs, n_fetch_hits, best_seen);
    if (errors == 0 && expected_resps.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/lsef_pkg.sv
sv/lsef_ram.sv
sv/lsef_cmp.sv
sv/largest_scc_edge_filter.sv
sv/lsef_chk.sv
bench/tb.sv
